>>> rtl/core/assert_macros.svh
// Assertion macros shared by the fusion core RTL.
// Every macro samples on clock and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must never hold.
`define ASSERT_NEVER(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("assertion violated: condition must never hold");

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion violated: same-cycle implication");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion violated: next-cycle implication");

`endif

>>> rtl/core/mvf_pkg.sv
// Package for the majority vote margin fusion core.
// Holds sizing constants and the request, response, group and divider types.
package mvf_pkg;

   localparam int MAX_VOTERS  = 16;
   localparam int MARGIN_BITS = 16;
   localparam int COUNT_BITS  = $clog2(MAX_VOTERS + 1);
   localparam int TOTAL_BITS  = COUNT_BITS + 1;
   localparam int SUM_BITS    = MARGIN_BITS + COUNT_BITS;
   localparam int STEP_BITS   = $clog2(SUM_BITS);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic                          vote_label;
      logic signed [MARGIN_BITS-1:0] margin;
      logic                          last_voter;
   } req_type;

   typedef struct packed {
      logic                          fused_label;
      logic signed [MARGIN_BITS-1:0] fused_margin;
   } rsp_type;

   // Totals of one closed group, handed from front to back
   typedef struct packed {
      logic        [COUNT_BITS-1:0] pos_count;
      logic        [COUNT_BITS-1:0] neg_count;
      logic signed [SUM_BITS-1:0]   pos_sum;
      logic signed [SUM_BITS-1:0]   neg_sum;
   } group_type;

   typedef struct packed {
      logic                       start;
      logic signed [SUM_BITS-1:0] dividend;
      logic [COUNT_BITS-1:0]      divisor;
   } div_req_type;

   typedef struct packed {
      logic                       busy;
      logic                       done;
      logic signed [SUM_BITS-1:0] quotient;
   } div_rsp_type;

endpackage

>>> rtl/core/mvf_front.sv
// Front end: takes vote requests, holds the mode register and accumulates
// per-side counts and margin sums. Depends on mvf_pkg and assert_macros.svh.
`include "assert_macros.svh"
module mvf_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_en,
   input  logic                csr_write_data,
   input  logic                req_valid,
   output logic                req_ready,
   input  mvf_pkg::req_type    req_payload,
   output logic                grp_valid,
   input  logic                grp_ready,
   output mvf_pkg::group_type  grp_data
);
   import mvf_pkg::*;

   logic                       vote_from_sign_ff, vote_from_sign_in;
   logic [COUNT_BITS-1:0]      pos_count_ff, pos_count_in;
   logic [COUNT_BITS-1:0]      neg_count_ff, neg_count_in;
   logic signed [SUM_BITS-1:0] pos_sum_ff, pos_sum_in;
   logic signed [SUM_BITS-1:0] neg_sum_ff, neg_sum_in;

   logic                       accept;
   logic                       vote;
   logic                       room;
   logic [TOTAL_BITS-1:0]      total;
   logic signed [SUM_BITS-1:0] margin_ext;
   group_type                  upd;

   // A closing request needs a queue slot; hold everything while full
   assign req_ready = grp_ready;
   assign accept    = req_valid && req_ready;
   assign grp_valid = accept && req_payload.last_voter;

   // Vote source: label, or sign of the margin in sign mode
   assign vote = vote_from_sign_ff ? ~req_payload.margin[MARGIN_BITS-1]
                                   : req_payload.vote_label;
   assign margin_ext = {{COUNT_BITS{req_payload.margin[MARGIN_BITS-1]}}, req_payload.margin};
   assign total = {1'b0, pos_count_ff} + {1'b0, neg_count_ff};
   assign room  = total < TOTAL_BITS'(MAX_VOTERS);

   // Totals including this request; votes past the limit are dropped
   always_comb begin
      upd.pos_count = pos_count_ff;
      upd.neg_count = neg_count_ff;
      upd.pos_sum   = pos_sum_ff;
      upd.neg_sum   = neg_sum_ff;
      if (room) begin
         if (vote) begin
            upd.pos_count = pos_count_ff + 1'b1;
            upd.pos_sum   = pos_sum_ff + margin_ext;
         end else begin
            upd.neg_count = neg_count_ff + 1'b1;
            upd.neg_sum   = neg_sum_ff + margin_ext;
         end
      end
   end

   assign grp_data = upd;

   // Next state: accumulate, or clear after the closing request
   always_comb begin
      vote_from_sign_in = csr_write_en ? csr_write_data : vote_from_sign_ff;
      pos_count_in = pos_count_ff;
      neg_count_in = neg_count_ff;
      pos_sum_in   = pos_sum_ff;
      neg_sum_in   = neg_sum_ff;
      if (accept) begin
         if (req_payload.last_voter) begin
            pos_count_in = '0;
            neg_count_in = '0;
            pos_sum_in   = '0;
            neg_sum_in   = '0;
         end else begin
            pos_count_in = upd.pos_count;
            neg_count_in = upd.neg_count;
            pos_sum_in   = upd.pos_sum;
            neg_sum_in   = upd.neg_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vote_from_sign_ff <= 1'b0;
         pos_count_ff      <= '0;
         neg_count_ff      <= '0;
         pos_sum_ff        <= '0;
         neg_sum_ff        <= '0;
      end else begin
         vote_from_sign_ff <= vote_from_sign_in;
         pos_count_ff      <= pos_count_in;
         neg_count_ff      <= neg_count_in;
         pos_sum_ff        <= pos_sum_in;
         neg_sum_ff        <= neg_sum_in;
      end
   end

   // Vote counts never exceed the voter limit
   `ASSERT_NEVER(a_front_overcount, total > TOTAL_BITS'(MAX_VOTERS))
   // A group is only handed over when the queue has a slot
   `ASSERT_IMPLIES(a_front_push_room, grp_valid, grp_ready)

endmodule

>>> rtl/core/mvf_queue.sv
// Short queue of closed group totals between front and back.
// Depends on mvf_pkg and assert_macros.svh.
`include "assert_macros.svh"
module mvf_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  mvf_pkg::group_type  push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output mvf_pkg::group_type  pop_data
);
   import mvf_pkg::*;

   group_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;
   logic                   push, pop;

   assign push_ready = count_ff < QCNT_BITS'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   // Pointer and fill count update with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `ASSERT_NEVER(a_queue_overfill, count_ff > QCNT_BITS'(QUEUE_DEPTH))
   // Pointers agree with the fill count when the queue is empty or full
   `ASSERT_IMPLIES(a_queue_ptr_sync, count_ff == '0 || count_ff == QCNT_BITS'(QUEUE_DEPTH),
                   wr_ptr_ff == rd_ptr_ff)

endmodule

>>> rtl/core/mvf_div.sv
// Radix-2 restoring divider: signed sum by unsigned count, quotient
// truncated toward zero, zero count gives zero. Depends on mvf_pkg and assert_macros.svh.
`include "assert_macros.svh"
module mvf_div (
   input  logic                  clock,
   input  logic                  reset,
   input  mvf_pkg::div_req_type  div_req,
   output mvf_pkg::div_rsp_type  div_rsp
);
   import mvf_pkg::*;

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [STEP_BITS-1:0]   step_ff, step_in;
   logic [SUM_BITS-1:0]    quo_ff, quo_in;
   logic [COUNT_BITS-1:0]  rem_ff, rem_in;
   logic [COUNT_BITS-1:0]  den_ff, den_in;
   logic                   neg_ff, neg_in;
   logic                   zero_ff, zero_in;

   logic [COUNT_BITS:0]    shifted;
   logic [COUNT_BITS:0]    diff;
   logic                   fits;
   logic [SUM_BITS-1:0]    dividend_mag;

   assign dividend_mag = div_req.dividend[SUM_BITS-1] ? SUM_BITS'(-div_req.dividend)
                                                      : SUM_BITS'(div_req.dividend);

   // One quotient bit per cycle
   assign shifted = {rem_ff, quo_ff[SUM_BITS-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign fits    = shifted >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = STEP_BITS'(SUM_BITS - 1);
         quo_in  = dividend_mag;
         rem_in  = '0;
         den_in  = div_req.divisor;
         neg_in  = div_req.dividend[SUM_BITS-1];
         zero_in = div_req.divisor == '0;
      end else if (busy_ff) begin
         rem_in = fits ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
         quo_in = {quo_ff[SUM_BITS-2:0], fits};
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath registers, no reset
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
   end

   // Restore the sign; empty side reads as zero
   always_comb begin
      div_rsp.busy = busy_ff;
      div_rsp.done = done_ff;
      if (zero_ff) begin
         div_rsp.quotient = '0;
      end else if (neg_ff) begin
         div_rsp.quotient = -$signed(quo_ff);
      end else begin
         div_rsp.quotient = $signed(quo_ff);
      end
   end

   `ASSERT_NEVER(a_div_restart, div_req.start && busy_ff)
   `ASSERT_NEXT(a_div_done_pulse, done_ff, !done_ff)

endmodule

>>> rtl/core/mvf_back.sv
// Back end: takes closed groups, computes both side means on the shared
// divider, picks the winner and holds the response. Depends on mvf_pkg and assert_macros.svh.
`include "assert_macros.svh"
module mvf_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  grp_valid,
   output logic                  grp_ready,
   input  mvf_pkg::group_type    grp_data,
   output mvf_pkg::div_req_type  div_req,
   input  mvf_pkg::div_rsp_type  div_rsp,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output mvf_pkg::rsp_type      rsp_payload
);
   import mvf_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_POS  = 2'd1;
   localparam logic [1:0] S_NEG  = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   logic [1:0]                    state_ff, state_in;
   group_type                     group_ff, group_in;
   logic signed [MARGIN_BITS-1:0] pos_mean_ff, pos_mean_in;
   logic signed [MARGIN_BITS-1:0] neg_mean_ff, neg_mean_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   rsp_type                       rsp_ff, rsp_in;

   logic                          pop;
   logic                          load;
   logic signed [MARGIN_BITS:0]   pos_ext, neg_mag;
   rsp_type                       decide;

   assign grp_ready = state_ff == S_IDLE;
   assign pop       = grp_valid && grp_ready;
   assign load      = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);

   // Positive mean starts on pop, negative mean when the first finishes
   always_comb begin
      div_req.start    = pop || (state_ff == S_POS && div_rsp.done);
      div_req.dividend = (state_ff == S_IDLE) ? grp_data.pos_sum : group_ff.neg_sum;
      div_req.divisor  = (state_ff == S_IDLE) ? grp_data.pos_count : group_ff.neg_count;
   end

   // Majority by count; on a tie, positive wins only if its mean exceeds |negative mean|
   assign pos_ext = {pos_mean_ff[MARGIN_BITS-1], pos_mean_ff};
   assign neg_mag = neg_mean_ff[MARGIN_BITS-1] ? -{neg_mean_ff[MARGIN_BITS-1], neg_mean_ff}
                                               :  {neg_mean_ff[MARGIN_BITS-1], neg_mean_ff};
   always_comb begin
      if (group_ff.pos_count < group_ff.neg_count) begin
         decide.fused_label  = 1'b0;
         decide.fused_margin = neg_mean_ff;
      end else if (group_ff.pos_count > group_ff.neg_count) begin
         decide.fused_label  = 1'b1;
         decide.fused_margin = pos_mean_ff;
      end else if (pos_ext > neg_mag) begin
         decide.fused_label  = 1'b1;
         decide.fused_margin = pos_mean_ff;
      end else begin
         decide.fused_label  = 1'b0;
         decide.fused_margin = neg_mean_ff;
      end
   end

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      group_in    = group_ff;
      pos_mean_in = pos_mean_ff;
      neg_mean_in = neg_mean_ff;
      case (state_ff)
         S_IDLE: begin
            if (pop) begin
               group_in = grp_data;
               state_in = S_POS;
            end
         end
         S_POS: begin
            if (div_rsp.done) begin
               pos_mean_in = div_rsp.quotient[MARGIN_BITS-1:0];
               state_in    = S_NEG;
            end
         end
         S_NEG: begin
            if (div_rsp.done) begin
               neg_mean_in = div_rsp.quotient[MARGIN_BITS-1:0];
               state_in    = S_OUT;
            end
         end
         S_OUT: begin
            if (load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = decide;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      group_ff    <= group_in;
      pos_mean_ff <= pos_mean_in;
      neg_mean_ff <= neg_mean_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Divider results arrive only while a mean is pending
   `ASSERT_IMPLIES(a_back_done_state, div_rsp.done, state_ff == S_POS || state_ff == S_NEG)
   // The divider is idle whenever the sequencer is not computing a mean
   `ASSERT_IMPLIES(a_back_div_idle, state_ff == S_IDLE || state_ff == S_OUT, !div_rsp.busy)

endmodule

>>> rtl/core/majority_vote_margin_fusion_core.sv
// Top level of the majority vote margin fusion core.
// Depends on mvf_pkg, mvf_front, mvf_queue, mvf_div and mvf_back.
//
//   Channel   Ports                               Direction   Moves
//   req       req_valid/req_ready/req_payload     in          one vote per request
//   rsp       rsp_valid/rsp_ready/rsp_payload     out         one fused result per group
//   csr       csr_write_en/csr_write_data         in          vote_from_sign mode bit
//
// The front accepts one request per cycle while the group queue has room.
// In the back, each closed group runs the shared one-bit-per-cycle divider for
// both means in turn; the back takes the next group only after loading a response.
// The queue holds two closed groups, so the front keeps taking votes while
// the back divides and while a finished response waits on rsp_ready.
// Reset is synchronous and clears counts, sums, the queue and the mode bit.
module majority_vote_margin_fusion_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_en,
   input  logic              csr_write_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  mvf_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mvf_pkg::rsp_type  rsp_payload
);
   import mvf_pkg::*;

   logic         push_valid, push_ready;
   group_type    push_data;
   logic         pop_valid, pop_ready;
   group_type    pop_data;
   div_req_type  div_req;
   div_rsp_type  div_rsp;

   // Accumulate votes
   mvf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_payload    (req_payload),
      .grp_valid      (push_valid),
      .grp_ready      (push_ready),
      .grp_data       (push_data)
   );

   // Group totals queue
   mvf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Shared mean divider
   mvf_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Resolve and respond
   mvf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .grp_valid   (pop_valid),
      .grp_ready   (pop_ready),
      .grp_data    (pop_data),
      .div_req     (div_req),
      .div_rsp     (div_rsp),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
